>>> sv/rotated_sorted_array_search_assert.svh
// ---------------------------------------------------------------------------
// Rotated sorted array search - assertion macros
// Concurrent assertion wrappers; empty bodies in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// clocked property, disabled during reset
`define RSAS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset too
`define RSAS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RSAS_ASSERT(label, clk, rst_n, prop, msg)
`define RSAS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> sv/rsas_pkg.sv
// ---------------------------------------------------------------------------
// Rotated sorted array search - package
// Payload types, search sequencer states and shared constants.
// ---------------------------------------------------------------------------
package rsas_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 10;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
    logic                    first;
  } rsas_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } rsas_out_t;

  typedef struct packed {
    logic      valid;
    rsas_out_t data;
  } rsas_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_RD_MID,
    S_CMP,
    S_RD_HI,
    S_CMP_HI,
    S_FINAL,
    S_RESULT
  } rsas_state_t;

endpackage

>>> sv/rsas_ram.sv
// ---------------------------------------------------------------------------
// Rotated sorted array search - generic single-port RAM
// One access per cycle, write or read; read data registered.
// ---------------------------------------------------------------------------
module rsas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/rsas_ctrl.sv
// ---------------------------------------------------------------------------
// Rotated sorted array search - load and search sequencer
// Appends elements to the store and runs the halving search over it.
// ---------------------------------------------------------------------------
module rsas_ctrl #(
  parameter int   DEPTH = rsas_pkg::DEPTH_DEF,
  localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int  CW    = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rsas_pkg::rsas_in_t              in_data,
  input  logic                            out_free,
  output rsas_pkg::rsas_res_t             res,
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_addr,
  output logic [rsas_pkg::VAL_W-1:0]      ram_wdata,
  input  logic [rsas_pkg::VAL_W-1:0]      ram_rdata
);

  rsas_pkg::rsas_state_t state_r, state_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  logic [AW-1:0]                       lo_r, lo_nxt;
  logic [AW-1:0]                       hi_r, hi_nxt;
  logic signed [rsas_pkg::VAL_W-1:0]   key_r, key_nxt;
  logic signed [rsas_pkg::VAL_W-1:0]   kl_r, kl_nxt;
  logic signed [rsas_pkg::VAL_W-1:0]   kn_r, kn_nxt;
  rsas_pkg::rsas_out_t                 res_r, res_nxt;

  logic signed [rsas_pkg::VAL_W-1:0]   rd_val;
  logic [AW:0]                         mid_sum;
  logic [AW-1:0]                       mid;
  logic [AW-1:0]                       mid_inc;
  logic [CW-1:0]                       base;
  logic                                base_ok;
  logic [CW-1:0]                       cnt_m1;
  logic [AW+rsas_pkg::POS_W-1:0]       lo_ext;
  logic                                is_load;

  assign rd_val   = $signed(ram_rdata);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[AW:1];
  assign mid_inc  = mid + AW'(1);
  assign base     = in_data.first ? '0 : count_r;
  assign base_ok  = base < CW'(DEPTH);
  assign cnt_m1   = count_r - CW'(1);
  assign lo_ext   = {{rsas_pkg::POS_W{1'b0}}, lo_r};
  assign is_load  = in_data.kind == rsas_pkg::KIND_LOAD;

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    key_nxt   = key_r;
    kl_nxt    = kl_r;
    kn_nxt    = kn_r;
    res_nxt   = res_r;
    case (state_r)
      rsas_pkg::S_IDLE: begin
        if (in_valid) begin
          if (is_load) begin
            count_nxt = base_ok ? base + CW'(1) : base;
          end else begin
            key_nxt = in_data.value;
            if (count_r == '0) begin
              res_nxt   = '0;
              state_nxt = rsas_pkg::S_RESULT;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = cnt_m1[AW-1:0];
              state_nxt = rsas_pkg::S_LOOP;
            end
          end
        end
      end
      rsas_pkg::S_LOOP: begin
        state_nxt = (lo_r < hi_r) ? rsas_pkg::S_RD_MID : rsas_pkg::S_FINAL;
      end
      rsas_pkg::S_RD_MID: begin
        kl_nxt    = rd_val;
        state_nxt = rsas_pkg::S_CMP;
      end
      rsas_pkg::S_CMP: begin
        if (kl_r <= rd_val) begin
          // left half sorted
          if (kl_r <= key_r && key_r <= rd_val) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid_inc;
          end
          state_nxt = rsas_pkg::S_LOOP;
        end else begin
          state_nxt = rsas_pkg::S_RD_HI;
        end
      end
      rsas_pkg::S_RD_HI: begin
        kn_nxt    = rd_val;
        state_nxt = rsas_pkg::S_CMP_HI;
      end
      rsas_pkg::S_CMP_HI: begin
        // right half sorted
        if (kn_r <= key_r && key_r <= rd_val) begin
          lo_nxt = mid_inc;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = rsas_pkg::S_LOOP;
      end
      rsas_pkg::S_FINAL: begin
        res_nxt.found    = rd_val == key_r;
        res_nxt.position = (rd_val == key_r) ? lo_ext[rsas_pkg::POS_W-1:0] : '0;
        state_nxt        = rsas_pkg::S_RESULT;
      end
      rsas_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = rsas_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rsas_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and store port
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = lo_r;
    ram_wdata = in_data.value;
    res.valid = 1'b0;
    res.data  = res_r;
    case (state_r)
      rsas_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_valid && is_load && base_ok;
        ram_addr = base[AW-1:0];
      end
      rsas_pkg::S_LOOP:   ram_addr = lo_r;
      rsas_pkg::S_RD_MID: ram_addr = mid;
      rsas_pkg::S_CMP:    ram_addr = mid_inc;
      rsas_pkg::S_RD_HI:  ram_addr = hi_r;
      rsas_pkg::S_RESULT: res.valid = 1'b1;
      default: begin
        ram_addr = lo_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsas_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    key_r <= key_nxt;
    kl_r  <= kl_nxt;
    kn_r  <= kn_nxt;
    res_r <= res_nxt;
  end

endmodule

>>> sv/rotated_sorted_array_search.sv
// ---------------------------------------------------------------------------
// Rotated sorted array search - top level
// Element store, search sequencer and registered result output.
// ---------------------------------------------------------------------------
//  channel  ports                         request
//  in       in_valid/in_ready/in_data      load one element or search a key
//  out      out_valid/out_ready/out_data   found flag and position
//
//  Load: one write to the store.
//  Search: an accept step, then per halving step S_LOOP, S_RD_MID and
//  S_CMP (plus S_RD_HI and S_CMP_HI when the left half holds the pivot),
//  set by the single store port; then a final read and handover.
//  Reset clears the element count and sequencer state; store contents stay undefined.
//  A waiting result sits in the output register; a second result holds
//  in_ready low until that register frees up.
// ---------------------------------------------------------------------------
`include "rotated_sorted_array_search_assert.svh"

module rotated_sorted_array_search #(
  parameter int  DEPTH = rsas_pkg::DEPTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rsas_pkg::rsas_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsas_pkg::rsas_out_t  out_data
);

  rsas_pkg::rsas_res_t             res;
  logic                            out_free;
  logic                            out_valid_r;
  rsas_pkg::rsas_out_t             out_data_r;
  logic                            ram_we;
  logic [AW-1:0]                   ram_addr;
  logic [rsas_pkg::VAL_W-1:0]      ram_wdata;
  logic [rsas_pkg::VAL_W-1:0]      ram_rdata;

  assign out_free = !out_valid_r || out_ready;

  rsas_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_free  (out_free),
    .res       (res),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  rsas_ram #(
    .WIDTH (rsas_pkg::VAL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid && out_free) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RSAS_ASSERT(a_no_accept_with_result, clk, rst_n, !(in_ready && res.valid), "input taken with result pending")
  `RSAS_ASSERT(a_result_held, clk, rst_n, (res.valid && !out_free) |=> (res.valid && $stable(res.data)), "pending result dropped")
  `RSAS_ASSERT(a_out_from_result, clk, rst_n, $rose(out_valid) |-> $past(res.valid), "output without a result")
  `RSAS_ASSERT(a_no_write_in_search, clk, rst_n, ram_we |-> in_ready, "store written during a search")

endmodule
